>>> src/bbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur row running sum: shared package
// Sizes, register codes, queue command and divider input types.
// ----------------------------------------------------------------------------
package bbr_pkg;

    // Sizing
    localparam int MAX_RADIUS  = 256;
    localparam int MAX_ROW     = 4096;
    localparam int RING_DEPTH  = MAX_RADIUS + 1;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int BACK_W      = $clog2(RING_DEPTH + 1);
    localparam int GIVEN_W     = $clog2(MAX_ROW + 1);
    localparam int SEEN_W      = 13;
    localparam int SEEN_MAX    = (1 << SEEN_W) - 1;

    // Pixel and sums
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PIX_W       = CHAN_W * NUM_CHAN;
    localparam int SUM_W       = 16;

    // Divider pipeline
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = SUM_W / DIV_BITS;

    // Command queue
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Configuration port
    localparam int TAPS_W      = 9;
    localparam int LEAD_W      = 9;
    localparam int ROWLEN_W    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TAPS_W-1:0]   TAPS_RESET   = TAPS_W'(5);
    localparam logic [LEAD_W-1:0]   LEAD_RESET   = LEAD_W'(2);
    localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = ROWLEN_W'(64);

    localparam logic KIND_PAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_TAPS = 2'd0,
        CFG_LEAD_OFFSET = 2'd1,
        CFG_ROW_LENGTH  = 2'd2
    } t_cfg_idx;

    // Where a window edge pixel comes from
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_CUR  = 2'd1,
        SRC_RAM  = 2'd2
    } t_src;

    // Clamped and derived configuration
    typedef struct packed {
        logic [BACK_W-1:0]  taps;
        logic [BACK_W-1:0]  enter_back;
        logic [BACK_W-1:0]  leave_back;
        logic [BACK_W-1:0]  delay;
        logic [GIVEN_W-1:0] rowlen;
    } t_cfg;

    // One classified word, front to back
    typedef struct packed {
        logic               start;
        logic [PIX_W-1:0]   pix;
        logic [RING_AW-1:0] wr_addr;
        t_src               enter_src;
        logic [RING_AW-1:0] enter_addr;
        t_src               leave_src;
        logic [RING_AW-1:0] leave_addr;
        logic               emit;
        logic               row_end;
    } t_cmd;

    typedef logic [NUM_CHAN-1:0][SUM_W-1:0] t_sums;

    typedef struct packed {
        logic  valid;
        logic  row_end;
        logic  zero;
        t_sums sums;
    } t_div_in;

endpackage

>>> src/bbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one registered read port, read returns the old contents.
// ----------------------------------------------------------------------------
module bbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur front end
// Accepts input words, tracks row position, classifies window edges.
// ----------------------------------------------------------------------------
module bbr_front
    import bbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_hold,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic              i_row_start,
    input  logic [CHAN_W-1:0] i_in_red,
    input  logic [CHAN_W-1:0] i_in_green,
    input  logic [CHAN_W-1:0] i_in_blue,
    input  logic [CHAN_W-1:0] i_in_alpha,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [SEEN_W-1:0]  r_items_seen;
    logic [GIVEN_W-1:0] r_outputs_given;
    logic [RING_AW-1:0] r_write_pos;

    logic [SEEN_W-1:0]  w_seen;
    logic [SEEN_W-1:0]  n_items_seen;
    logic [GIVEN_W-1:0] w_given;
    logic [GIVEN_W-1:0] n_outputs_given;
    logic [RING_AW-1:0] w_wp;
    logic [RING_AW-1:0] n_write_pos;
    logic               w_emit;

    // Ring slot that lies back entries behind the write position
    function automatic logic [RING_AW-1:0] ring_addr(input logic [RING_AW-1:0] wp,
                                                     input logic [BACK_W-1:0]  back);
        logic [RING_AW+1:0] s;
        s = (RING_AW+2)'(wp) + (RING_AW+2)'(RING_DEPTH) - (RING_AW+2)'(back);
        if (s >= (RING_AW+2)'(RING_DEPTH)) begin
            s = s - (RING_AW+2)'(RING_DEPTH);
        end
        return s[RING_AW-1:0];
    endfunction

    assign o_in_ready = ~i_q_full & ~i_hold;
    assign o_push     = i_in_valid & o_in_ready;

    // Row start clears position before this word is counted
    assign w_seen  = i_row_start ? '0 : r_items_seen;
    assign w_given = i_row_start ? '0 : r_outputs_given;
    assign w_wp    = i_row_start ? '0 : r_write_pos;

    assign n_items_seen = (w_seen == SEEN_W'(SEEN_MAX)) ? w_seen : w_seen + SEEN_W'(1);
    assign n_write_pos  = (w_wp == RING_AW'(RING_DEPTH - 1)) ? '0 : w_wp + RING_AW'(1);

    assign w_emit = (32'(n_items_seen) > 32'(i_cfg.delay)) && (w_given < i_cfg.rowlen);
    assign n_outputs_given = w_emit ? w_given + GIVEN_W'(1) : w_given;

    always_comb begin
        o_cmd.start      = i_row_start;
        o_cmd.pix        = (i_kind == KIND_PAD) ? '0
                         : {i_in_alpha, i_in_blue, i_in_green, i_in_red};
        o_cmd.wr_addr    = w_wp;
        o_cmd.enter_addr = ring_addr(w_wp, i_cfg.enter_back);
        o_cmd.leave_addr = ring_addr(w_wp, i_cfg.leave_back);
        o_cmd.emit       = w_emit;
        o_cmd.row_end    = w_emit && (n_outputs_given == i_cfg.rowlen);

        priority if (i_cfg.enter_back == '0) begin
            o_cmd.enter_src = SRC_CUR;
        end else if (32'(i_cfg.enter_back) > 32'(w_seen)) begin
            o_cmd.enter_src = SRC_ZERO;
        end else begin
            o_cmd.enter_src = SRC_RAM;
        end

        if (32'(i_cfg.leave_back) > 32'(w_seen)) begin
            o_cmd.leave_src = SRC_ZERO;
        end else begin
            o_cmd.leave_src = SRC_RAM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_seen    <= '0;
            r_outputs_given <= '0;
            r_write_pos     <= '0;
        end else if (o_push) begin
            r_items_seen    <= n_items_seen;
            r_outputs_given <= n_outputs_given;
            r_write_pos     <= n_write_pos;
        end
    end

endmodule

>>> src/bbr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur command queue
// Small FIFO of classified words between front end and back end.
// ----------------------------------------------------------------------------
module bbr_queue
    import bbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

>>> src/bbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur back end
// Delay line reads and writes, running channel sums, divider feed.
// ----------------------------------------------------------------------------
module bbr_back
    import bbr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    input  logic    i_adv,
    output t_div_in o_div
);

    logic             r_s1_valid;
    t_cmd             r_s1;
    t_sums            r_sum;
    t_sums            n_sum;
    logic [PIX_W-1:0] w_enter_ram;
    logic [PIX_W-1:0] w_leave_ram;
    logic [PIX_W-1:0] w_enter;
    logic [PIX_W-1:0] w_leave;

    assign o_pop = ~i_q_empty & i_adv;

    // Two copies of the delay line give two read ports
    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_enter (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_cmd.pix),
        .i_re    (o_pop),
        .i_raddr (i_cmd.enter_addr),
        .o_rdata (w_enter_ram)
    );

    bbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_leave (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (i_cmd.pix),
        .i_re    (o_pop),
        .i_raddr (i_cmd.leave_addr),
        .o_rdata (w_leave_ram)
    );

    always_comb begin
        unique case (r_s1.enter_src)
            SRC_CUR: w_enter = r_s1.pix;
            SRC_RAM: w_enter = w_enter_ram;
            default: w_enter = '0;
        endcase
        unique case (r_s1.leave_src)
            SRC_RAM: w_leave = w_leave_ram;
            default: w_leave = '0;
        endcase
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_sum[c] = (r_s1.start ? SUM_W'(0) : r_sum[c])
                     + SUM_W'(w_enter[c*CHAN_W +: CHAN_W])
                     - SUM_W'(w_leave[c*CHAN_W +: CHAN_W]);
        end
    end

    assign o_div.valid   = r_s1_valid & r_s1.emit;
    assign o_div.row_end = r_s1.row_end;
    assign o_div.zero    = (n_sum[NUM_CHAN-1] == '0);
    assign o_div.sums    = n_sum;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sum      <= '0;
        end else if (i_adv) begin
            r_s1_valid <= o_pop;
            if (r_s1_valid) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

>>> src/bbr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur divider pipeline
// Restoring division of four sums by the tap count, two bits per stage.
// ----------------------------------------------------------------------------
module bbr_div
    import bbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BACK_W-1:0] i_taps,
    input  t_div_in           i_div,
    input  logic              i_out_ready,
    output logic              o_adv,
    output logic              o_out_valid,
    output logic [CHAN_W-1:0] o_out_red,
    output logic [CHAN_W-1:0] o_out_green,
    output logic [CHAN_W-1:0] o_out_blue,
    output logic [CHAN_W-1:0] o_out_alpha,
    output logic              o_row_end
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] r_valid;
    logic [DIV_STAGES-1:0] r_row_end;
    logic [DIV_STAGES-1:0] r_zero;
    logic [BACK_W-1:0]     r_rem  [DIV_STAGES][NUM_CHAN];
    logic [SUM_W-1:0]      r_work [DIV_STAGES][NUM_CHAN];
    logic [BACK_W-1:0]     n_rem  [DIV_STAGES][NUM_CHAN];
    logic [SUM_W-1:0]      n_work [DIV_STAGES][NUM_CHAN];

    // Shift dividend bits out of work, quotient bits in
    function automatic logic [BACK_W+SUM_W-1:0] div_steps(input logic [BACK_W-1:0] rem_in,
                                                          input logic [SUM_W-1:0]  work_in,
                                                          input logic [BACK_W-1:0] dvs);
        logic [BACK_W:0]   t;
        logic [BACK_W-1:0] rem;
        logic [SUM_W-1:0]  work;
        rem  = rem_in;
        work = work_in;
        for (int k = 0; k < DIV_BITS; k++) begin
            t    = {rem, work[SUM_W-1]};
            work = {work[SUM_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t       = t - {1'b0, dvs};
                work[0] = 1'b1;
            end
            rem = t[BACK_W-1:0];
        end
        return {rem, work};
    endfunction

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
            if (s == 0) begin : g_first
                assign {n_rem[s][c], n_work[s][c]} = div_steps('0, i_div.sums[c], i_taps);
            end else begin : g_next
                assign {n_rem[s][c], n_work[s][c]} =
                    div_steps(r_rem[s-1][c], r_work[s-1][c], i_taps);
            end
        end
    end

    // Whole pipe moves unless a finished word waits at the end
    assign o_adv = ~r_valid[LAST] | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (o_adv) begin
            r_valid <= {r_valid[DIV_STAGES-2:0], i_div.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_row_end <= {r_row_end[DIV_STAGES-2:0], i_div.row_end};
            r_zero    <= {r_zero[DIV_STAGES-2:0], i_div.zero};
            for (int s = 0; s < DIV_STAGES; s++) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    r_rem[s][c]  <= n_rem[s][c];
                    r_work[s][c] <= n_work[s][c];
                end
            end
        end
    end

    assign o_out_valid = r_valid[LAST];
    assign o_row_end   = r_row_end[LAST];
    assign o_out_red   = r_zero[LAST] ? '0 : r_work[LAST][0][CHAN_W-1:0];
    assign o_out_green = r_zero[LAST] ? '0 : r_work[LAST][1][CHAN_W-1:0];
    assign o_out_blue  = r_zero[LAST] ? '0 : r_work[LAST][2][CHAN_W-1:0];
    assign o_out_alpha = r_zero[LAST] ? '0 : r_work[LAST][3][CHAN_W-1:0];

endmodule

>>> src/box_blur_row_running_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur row running sum
// One-dimensional RGBA box blur over a row, using a delay line and four
// running channel sums, followed by a pipelined divide by the tap count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready | i_kind, i_row_start,
//          |           |                         | i_in_red/green/blue/alpha
//  out     | output    | o_out_valid/i_out_ready | o_out_red/green/blue/alpha,
//          |           |                         | o_row_end
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One input word per cycle while the queue has room and no config write
//  holds input; each word passes through the queue, the delay-line read
//  register and DIV_STAGES divider stages before o_out_valid rises.
//  The running-sum add is the only loop; the divider is fully pipelined.
//  Reset (synchronous, active low) clears counters, sums and valid flags; the
//  delay line needs no clearing pass because the word count masks old entries.
//  An output stall freezes the back end; the queue keeps taking words until
//  it fills. A config write holds o_in_ready low for the following cycle.
//
// ----------------------------------------------------------------------------
module box_blur_row_running_sum
    import bbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic                  i_row_start,
    input  logic [CHAN_W-1:0]     i_in_red,
    input  logic [CHAN_W-1:0]     i_in_green,
    input  logic [CHAN_W-1:0]     i_in_blue,
    input  logic [CHAN_W-1:0]     i_in_alpha,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_out_red,
    output logic [CHAN_W-1:0]     o_out_green,
    output logic [CHAN_W-1:0]     o_out_blue,
    output logic [CHAN_W-1:0]     o_out_alpha,
    output logic                  o_row_end
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TAPS_W-1:0]   r_filter_taps;
    logic [LEAD_W-1:0]   r_lead_offset;
    logic [ROWLEN_W-1:0] r_row_length;
    logic                r_cfg_wait;
    t_cfg                r_cfg;
    t_cfg                n_cfg;

    logic                w_cfg_write;
    logic [BACK_W-1:0]   w_taps;
    logic [BACK_W-1:0]   w_lead;
    logic [GIVEN_W-1:0]  w_rowlen;
    logic [BACK_W:0]     w_lead_inc;
    logic [BACK_W-1:0]   w_enter_back;

    // Writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_taps <= TAPS_RESET;
            r_lead_offset <= LEAD_RESET;
            r_row_length  <= ROWLEN_RESET;
            r_cfg_wait    <= 1'b1;
        end else begin
            // Hold input in the cycle after a write so the derived settings catch up
            r_cfg_wait <= w_cfg_write;
            if (w_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_FILTER_TAPS: r_filter_taps <= i_cfg_data[TAPS_W-1:0];
                    CFG_LEAD_OFFSET: r_lead_offset <= i_cfg_data[LEAD_W-1:0];
                    CFG_ROW_LENGTH:  r_row_length  <= i_cfg_data[ROWLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Clamp out-of-range settings to the supported window and row
    always_comb begin
        priority if (r_filter_taps == '0) begin
            w_taps = BACK_W'(1);
        end else if (32'(r_filter_taps) > RING_DEPTH) begin
            w_taps = BACK_W'(RING_DEPTH);
        end else begin
            w_taps = BACK_W'(r_filter_taps);
        end

        if (32'(r_lead_offset) > MAX_RADIUS) begin
            w_lead = BACK_W'(MAX_RADIUS);
        end else begin
            w_lead = BACK_W'(r_lead_offset);
        end

        priority if (r_row_length == '0) begin
            w_rowlen = GIVEN_W'(1);
        end else if (32'(r_row_length) > MAX_ROW) begin
            w_rowlen = GIVEN_W'(MAX_ROW);
        end else begin
            w_rowlen = GIVEN_W'(r_row_length);
        end
    end

    // Window edges relative to the newest word, and the word delay before output starts
    assign w_lead_inc   = (BACK_W+1)'(w_lead) + (BACK_W+1)'(1);
    assign w_enter_back = (w_lead_inc > (BACK_W+1)'(w_taps))
                        ? BACK_W'(w_lead_inc - (BACK_W+1)'(w_taps)) : '0;

    always_comb begin
        n_cfg.taps       = w_taps;
        n_cfg.enter_back = w_enter_back;
        n_cfg.leave_back = BACK_W'((BACK_W+1)'(w_enter_back) + (BACK_W+1)'(w_taps));
        n_cfg.delay      = ((w_taps - BACK_W'(1)) >= w_lead)
                         ? (w_taps - BACK_W'(1) - w_lead) : '0;
        n_cfg.rowlen     = w_rowlen;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    // ------------------------------------------------------------------
    // Front end, queue, back end, divider
    // ------------------------------------------------------------------
    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_adv;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_div_in w_div;

    bbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (r_cfg_wait),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_row_start (i_row_start),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    bbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_q_empty)
    );

    bbr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_cmd_out),
        .o_pop     (w_pop),
        .i_adv     (w_adv),
        .o_div     (w_div)
    );

    bbr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_taps      (r_cfg.taps),
        .i_div       (w_div),
        .i_out_ready (i_out_ready),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_row_end   (o_row_end)
    );

endmodule

>>> src/bbr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur port checker
// Concurrent checks on the top-level ports, bound into the top level.
// ----------------------------------------------------------------------------
module bbr_chk
    import bbr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_kind,
    input logic                  i_row_start,
    input logic [CHAN_W-1:0]     i_in_red,
    input logic [CHAN_W-1:0]     i_in_green,
    input logic [CHAN_W-1:0]     i_in_blue,
    input logic [CHAN_W-1:0]     i_in_alpha,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [CHAN_W-1:0]     o_out_red,
    input logic [CHAN_W-1:0]     o_out_green,
    input logic [CHAN_W-1:0]     o_out_blue,
    input logic [CHAN_W-1:0]     o_out_alpha,
    input logic                  o_row_end
);

    logic [31:0] r_in_cnt;
    logic [31:0] r_out_cnt;

    // Count words moved on each side since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_cnt <= r_in_cnt + 32'd1;
            end
            if (o_out_valid && i_out_ready) begin
                r_out_cnt <= r_out_cnt + 32'd1;
            end
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_in_ready)
        else $error("input taken while derived settings settle");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_cnt < r_in_cnt))
        else $error("more results than accepted input words");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_kind) && $stable(i_row_start) &&
             $stable(i_in_red) && $stable(i_in_green) && $stable(i_in_blue) &&
             $stable(i_in_alpha)))
        else $error("waiting input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_red) && $stable(o_out_green) &&
             $stable(o_out_blue) && $stable(o_out_alpha) && $stable(o_row_end)))
        else $error("stalled result word changed");

endmodule

bind box_blur_row_running_sum bbr_chk u_bbr_chk (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur row running sum: block-level testbench
// Streams rows of RGBA pixels and pad ticks through the blur under several
// window and row settings. A scoreboard class keeps its own delay line and
// running sums, predicts every averaged pixel and compares each result word
// field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import bbr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 950;
    localparam int SETTLE_CYCLES = 60;    // pipeline depth plus queue, with margin
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int ROW_CAP       = 300;   // longest row sent in one go

    localparam logic                 KIND_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One averaged pixel as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last;
    } blur_px_t;

    // ------------------------------------------------------------------------
    // Scoreboard: running-sum blur predictor and queue of pending pixels
    // ------------------------------------------------------------------------
    class blur_row_checker;
        logic [TAPS_W-1:0]   taps_reg;
        logic [LEAD_W-1:0]   lead_reg;
        logic [ROWLEN_W-1:0] len_reg;
        logic [PIX_W-1:0]    ring [RING_DEPTH];
        logic [SUM_W-1:0]    acc [NUM_CHAN];
        int unsigned         seen;
        int unsigned         given;
        int unsigned         wpos;
        blur_px_t            pending_px [$];
        int                  errors;

        function new();
            taps_reg = TAPS_RESET;
            lead_reg = LEAD_RESET;
            len_reg  = ROWLEN_RESET;
            foreach (ring[i]) ring[i] = '0;
            foreach (acc[c]) acc[c] = '0;
            seen   = 0;
            given  = 0;
            wpos   = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FILTER_TAPS: taps_reg = data[TAPS_W-1:0];
                CFG_LEAD_OFFSET: lead_reg = data[LEAD_W-1:0];
                CFG_ROW_LENGTH:  len_reg  = data[ROWLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned taps();
            if (taps_reg < 1) return 1;
            if (taps_reg > RING_DEPTH) return RING_DEPTH;
            return 32'(taps_reg);
        endfunction

        function int unsigned lead();
            return (lead_reg > MAX_RADIUS) ? MAX_RADIUS : 32'(lead_reg);
        endfunction

        function int unsigned row_results();
            if (len_reg < 1) return 1;
            if (len_reg > MAX_ROW) return MAX_ROW;
            return 32'(len_reg);
        endfunction

        // words seen before the first averaged pixel can leave
        function int unsigned lag();
            return (taps() - 1 >= lead()) ? taps() - 1 - lead() : 0;
        endfunction

        function logic [PIX_W-1:0] look_back(int unsigned back, logic [PIX_W-1:0] cur);
            if (back == 0) return cur;
            if (back > seen || back > RING_DEPTH) return '0;
            return ring[(wpos + RING_DEPTH - back) % RING_DEPTH];
        endfunction

        function void take_word(logic kind, logic start, logic [CHAN_W-1:0] r,
                                logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                                logic [CHAN_W-1:0] a);
            int unsigned      n_taps;
            int unsigned      enter_back;
            logic [PIX_W-1:0] pix;
            logic [PIX_W-1:0] enter_px;
            logic [PIX_W-1:0] leave_px;
            blur_px_t         px;
            if (start) begin
                foreach (acc[c]) acc[c] = '0;
                seen  = 0;
                given = 0;
                wpos  = 0;
            end
            n_taps     = taps();
            pix        = (kind == KIND_PAD) ? '0 : {a, b, g, r};
            enter_back = (lead() + 1 > n_taps) ? lead() + 1 - n_taps : 0;
            enter_px   = look_back(enter_back, pix);
            leave_px   = look_back(enter_back + n_taps, pix);
            foreach (acc[c])
                acc[c] = acc[c] + enter_px[c*CHAN_W +: CHAN_W] - leave_px[c*CHAN_W +: CHAN_W];
            ring[wpos] = pix;
            wpos = (wpos + 1) % RING_DEPTH;
            if (seen < SEEN_MAX) seen++;
            if (seen <= lag() || given >= row_results()) return;
            px = '0;
            if (acc[3] != 0) begin
                px.red   = CHAN_W'(acc[0] / n_taps);
                px.green = CHAN_W'(acc[1] / n_taps);
                px.blue  = CHAN_W'(acc[2] / n_taps);
                px.alpha = CHAN_W'(acc[3] / n_taps);
            end
            given++;
            px.last = (given == row_results());
            pending_px = {pending_px, px};
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(blur_px_t got);
            blur_px_t want;
            if (pending_px.size() == 0) begin
                $error("result word with no pixel pending: %h", got);
                errors++;
                return;
            end
            want = pending_px.pop_front();
            field_check("out_red",   want.red,   got.red);
            field_check("out_green", want.green, got.green);
            field_check("out_blue",  want.blue,  got.blue);
            field_check("out_alpha", want.alpha, got.alpha);
            field_check("row_end",   want.last,  got.last);
        endfunction

        function int pending();
            return pending_px.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its ports
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic                  i_row_start;
    logic [CHAN_W-1:0]     i_in_red;
    logic [CHAN_W-1:0]     i_in_green;
    logic [CHAN_W-1:0]     i_in_blue;
    logic [CHAN_W-1:0]     i_in_alpha;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHAN_W-1:0]     o_out_red;
    logic [CHAN_W-1:0]     o_out_green;
    logic [CHAN_W-1:0]     o_out_blue;
    logic [CHAN_W-1:0]     o_out_alpha;
    logic                  o_row_end;

    box_blur_row_running_sum dut (.*);

    blur_row_checker sb = new();

    // handshake flags, set at the rising edge and read at the next falling one
    bit       in_taken;
    bit       cfg_taken;
    blur_px_t out_px;

    // receiver hold-off request from the stimulus side
    bit hold_req;
    bit hold_active;

    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned random_words;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor: note accepted words and register writes, check results.
    // Everything here sees the values that stood just before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken  = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_taken = 1'b1;
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                sb.take_word(i_kind, i_row_start, i_in_red, i_in_green, i_in_blue,
                             i_in_alpha);
            end
            if (o_out_valid && i_out_ready) begin
                out_px = {o_out_red, o_out_green, o_out_blue, o_out_alpha, o_row_end};
                sb.check_pixel(out_px);
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes at random intervals
    // (always ready, coin flip, one in three low, mostly stalled).
    // On request, hold ready low for a long stretch so the block backs up.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode        = 0;
        mode_left   = 0;
        tick        = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_active = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = 1'($urandom_range(0, 1));
                2: i_out_ready = (tick % 3 != 0);
                default: i_out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each one starts and ends at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one word; open a new burst with a random gap when the last ends.
    task automatic send_word(logic kind, logic start, logic [CHAN_W-1:0] r,
                             logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                             logic [CHAN_W-1:0] a);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 16);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_kind      = kind;
        i_row_start = start;
        i_in_red    = r;
        i_in_green  = g;
        i_in_blue   = b;
        i_in_alpha  = a;
        i_in_valid  = 1'b1;
        do @(negedge i_clk); while (!in_taken);
    endtask

    // Hold the input side until every pending pixel has come out.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0 || hold_req || hold_active) @(negedge i_clk);
    endtask

    // Drain, then give words that cause no result time to leave the pipe.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_W'(data);
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(int unsigned taps, int unsigned lead, int unsigned len);
        settle();
        write_cfg(CFG_FILTER_TAPS, taps);
        write_cfg(CFG_LEAD_OFFSET, lead);
        write_cfg(CFG_ROW_LENGTH, len);
    endtask

    // Channel value: tone 3 sticks to the extremes, others are uniform.
    function automatic logic [CHAN_W-1:0] pick_chan(int unsigned tone);
        if (tone == 3) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    // One row: row_start on the first pixel, the row's pixels, then enough
    // pad ticks to flush the window. A noisy row scrambles kind, drops or
    // adds row starts and runs short or long.
    task automatic send_row(bit noisy);
        int          count;
        int unsigned rlen;
        int unsigned tone;
        logic        kind;
        logic        start;
        rlen  = sb.row_results();
        tone  = $urandom_range(0, 3);
        count = int'(rlen + sb.lag());
        if (noisy) count = count + int'($urandom_range(0, 6)) - 3;
        if (count < 1) count = 1;
        if (count > ROW_CAP) count = ROW_CAP;
        for (int i = 0; i < count; i++) begin
            if (noisy) begin
                start = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
                kind  = ($urandom_range(0, 3) == 0) ? KIND_PAD : KIND_PIXEL;
            end else begin
                start = (i == 0);
                kind  = (i >= rlen) ? KIND_PAD : KIND_PIXEL;
            end
            // tone 2 keeps alpha at zero, so the whole row averages to zero
            send_word(kind, start, pick_chan(tone), pick_chan(tone), pick_chan(tone),
                      (tone == 2) ? 8'h00 : pick_chan(tone));
        end
        random_words += count;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_no;
        int unsigned budget;
        int unsigned start_words;
        int unsigned taps_d;
        int unsigned lead_d;
        int unsigned len_d;

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_PIXEL;
        i_row_start  = 1'b0;
        i_in_red     = '0;
        i_in_green   = '0;
        i_in_blue    = '0;
        i_in_alpha   = '0;
        hold_req     = 1'b0;
        hold_active  = 1'b0;
        burst_left   = 0;
        random_words = 0;
        phase_no     = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset window (5 taps, 2 lead), short row of four.
        write_cfg(CFG_ROW_LENGTH, 4);
        send_word(KIND_PIXEL, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_PIXEL, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(KIND_PIXEL, 1'b0, 8'd200, 8'd100, 8'd50, 8'h00);
        send_word(KIND_PIXEL, 1'b0, 8'd1, 8'd2, 8'd3, 8'd4);
        // pad ticks with nonzero channels still count as zero pixels
        send_word(KIND_PAD, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_PAD, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55);
        // past the row end: nothing comes out
        send_word(KIND_PIXEL, 1'b0, 8'd9, 8'd9, 8'd9, 8'd9);
        send_word(KIND_PIXEL, 1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        // zero alpha across the window forces all channels to zero
        send_word(KIND_PIXEL, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_word(KIND_PIXEL, 1'b0, 8'hFF, 8'h00, 8'h80, 8'h00);
        send_word(KIND_PIXEL, 1'b0, 8'h7F, 8'hFF, 8'h01, 8'h00);
        send_word(KIND_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_word(KIND_PAD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(KIND_PAD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);

        // Lead beyond the window: a result leaves for every word from the first.
        set_config(2, 3, 3);
        send_word(KIND_PIXEL, 1'b1, 8'd10, 8'd20, 8'd30, 8'd40);
        send_word(KIND_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_PIXEL, 1'b0, 8'd5, 8'd6, 8'd7, 8'd8);

        // Zero taps act as one, zero row length as one.
        set_config(0, 0, 0);
        send_word(KIND_PIXEL, 1'b1, 8'd33, 8'd66, 8'd99, 8'd132);
        send_word(KIND_PIXEL, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // The spare register index must be ignored.
        settle();
        write_cfg(CFG_UNUSED, 13'h1FFF);
        send_word(KIND_PIXEL, 1'b1, 8'd7, 8'd7, 8'd7, 8'd7);

        // Random phases: extremes first, then mostly small windows and rows.
        while (random_words < RANDOM_WORDS) begin
            case (phase_no)
                0: begin taps_d = 1;    lead_d = 0;    len_d = 1;    end
                1: begin taps_d = 257;  lead_d = 0;    len_d = 6;    end
                2: begin taps_d = 8191; lead_d = 8191; len_d = 8191; end
                3: begin taps_d = 0;    lead_d = 300;  len_d = 0;    end
                4: begin taps_d = 3;    lead_d = 5;    len_d = 7;    end
                5: begin taps_d = 300;  lead_d = 256;  len_d = 4096; end
                default: begin
                    taps_d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 12);
                    lead_d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(0, 14);
                    len_d  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 20);
                end
            endcase
            set_config(taps_d, lead_d, len_d);
            if (phase_no == 1 || $urandom_range(0, 9) == 0)
                write_cfg(CFG_UNUSED, $urandom_range(0, 8191));

            // back up the block once while words keep coming
            if (phase_no == 4) hold_req = 1'b1;

            budget      = $urandom_range(50, 90);
            start_words = random_words;
            while (random_words - start_words < budget) begin
                send_row($urandom_range(0, 6) == 0);
                // pause the input until the output side catches up
                if (phase_no == 6 || $urandom_range(0, 7) == 0) wait_drained();
            end
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
